// ===== rtl/dih_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dihedral angle package
// Shared constants and small tables for the dihedral angle stream block.
// ----------------------------------------------------------------------------
package dih_pkg;

  localparam int COORD_BITS_DEF        = 24;
  localparam int ANGLE_FRAC_BITS_DEF   = 6;
  localparam int CORDIC_ITERATIONS_DEF = 20;

  localparam int RED_BITS   = 19;
  localparam int CIN_BITS   = 30;
  localparam int ZFRAC      = 24;
  localparam int ANGLE_BITS = 15;
  localparam int ATAN_BITS  = 30;

  function automatic logic [ATAN_BITS-1:0] atan_tab(input logic [4:0] i);
    logic [ATAN_BITS-1:0] r;
    unique case (i)
      5'd0:  r = 30'd754974720;
      5'd1:  r = 30'd445687602;
      5'd2:  r = 30'd235489088;
      5'd3:  r = 30'd119537938;
      5'd4:  r = 30'd60000934;
      5'd5:  r = 30'd30029717;
      5'd6:  r = 30'd15018523;
      5'd7:  r = 30'd7509720;
      5'd8:  r = 30'd3754917;
      5'd9:  r = 30'd1877466;
      5'd10: r = 30'd938734;
      5'd11: r = 30'd469367;
      5'd12: r = 30'd234684;
      5'd13: r = 30'd117342;
      5'd14: r = 30'd58671;
      5'd15: r = 30'd29335;
      5'd16: r = 30'd14668;
      5'd17: r = 30'd7334;
      5'd18: r = 30'd3667;
      5'd19: r = 30'd1833;
      5'd20: r = 30'd917;
      5'd21: r = 30'd458;
      5'd22: r = 30'd229;
      5'd23: r = 30'd115;
      5'd24: r = 30'd57;
      5'd25: r = 30'd29;
      5'd26: r = 30'd14;
      5'd27: r = 30'd7;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Component index of a cross product term: first or second factor.
  function automatic logic [1:0] cross_idx(input logic [1:0] j, input logic t);
    logic [1:0] r;
    unique case (j)
      2'd0:    r = t ? 2'd2 : 2'd1;
      2'd1:    r = t ? 2'd0 : 2'd2;
      default: r = t ? 2'd1 : 2'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dih_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dihedral angle channels
// Point request channel and angle result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dih_point_if #(
  parameter int COORD_BITS = dih_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         chain_start;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source(output valid, chain_start, coord_x, coord_y, coord_z, input ready);
  modport sink(input valid, chain_start, coord_x, coord_y, coord_z, output ready);
endinterface

interface dih_result_if;
  logic                           valid;
  logic                           ready;
  logic [dih_pkg::ANGLE_BITS-1:0] angle;
  logic                           degenerate;

  modport source(output valid, angle, degenerate, input ready);
  modport sink(input valid, angle, degenerate, output ready);
endinterface
`default_nettype wire

// ===== rtl/dihedral_angle_stream.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dihedral angle stream
// Dihedral angle of the last four points of a chain, by shared multiplier,
// serial square root and CORDIC.
// ----------------------------------------------------------------------------
// A point request that starts a chain, or that belongs to the first three
// points of a chain, is only stored and gives no result. Every later point
// gives one result and keeps the block busy for 34 multiply-accumulate
// passes through one shared multiplier, two 20-step bit-serial square roots,
// CORDIC_ITERATIONS CORDIC steps and five block-scaling passes.
// Collinear points end early with the degenerate flag set and angle zero.
// A finished result waits in an output register, and the next point request
// is taken while it waits.
module dihedral_angle_stream #(
  parameter int COORD_BITS        = dih_pkg::COORD_BITS_DEF,
  parameter int ANGLE_FRAC_BITS   = dih_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_ITERATIONS = dih_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  dih_point_if.sink    point,
  dih_result_if.source result
);

  localparam int D    = COORD_BITS + 1;
  localparam int MW   = (D > 22) ? D : 22;
  localparam int PW   = 2 * MW;
  localparam int AW   = (2 * D + 2 > 64) ? 2 * D + 2 : 64;
  localparam int RB   = dih_pkg::RED_BITS;
  localparam int CB   = dih_pkg::CIN_BITS;
  localparam int NW   = RB + 1;
  localparam int CW   = CB + 1;
  localparam int DW   = 2 * RB + 4;
  localparam int QW   = 2 * RB + 2;
  localparam int SW   = RB + 1;
  localparam int XW   = CB + 4;
  localparam int ZW   = dih_pkg::ZFRAC + 12;
  localparam int SH   = dih_pkg::ZFRAC - ANGLE_FRAC_BITS;
  localparam int CNTW = 6;
  localparam int AB   = dih_pkg::ANGLE_BITS;

  localparam logic signed [ZW-1:0] Z180  = ZW'(180) <<< dih_pkg::ZFRAC;
  localparam logic signed [ZW-1:0] Z360  = ZW'(360) <<< dih_pkg::ZFRAC;
  localparam logic signed [ZW-1:0] ZHALF = ZW'(1) <<< (SH - 1);
  localparam logic signed [ZW-1:0] Q360  = ZW'(360) <<< ANGLE_FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_N1, S_N2, S_M1, S_RED, S_DOT, S_SQ, S_XY, S_CORD, S_FIN1, S_FIN2,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {PH_N1, PH_N2, PH_V2, PH_M1, PH_CXY} phase_t;

  state_t state;
  phase_t phase;
  logic [CNTW-1:0] cnt;
  logic [1:0] seen;

  logic signed [COORD_BITS-1:0] hist [3][3];
  logic signed [D-1:0] v1 [3];
  logic signed [D-1:0] v2 [3];
  logic signed [D-1:0] v3 [3];
  logic signed [NW-1:0] n1s [3];
  logic signed [NW-1:0] n2s [3];
  logic signed [NW-1:0] vrs [3];
  logic signed [NW-1:0] mr [3];
  logic [AW-1:0] rm [3];
  logic [2:0] rs;
  logic signed [DW-1:0] dots [4];
  logic signed [AW-1:0] acc;

  logic signed [PW-1:0] p;
  logic p_valid, p_neg, p_first, p_last, p_shift, p_dot;
  logic [1:0] p_idx;

  logic [QW-1:0] sq_v;
  logic [QW:0] sq_r;
  logic [QW-1:0] sq_bit;
  logic sq_second;
  logic [SW-1:0] ln1, lm;

  logic signed [XW-1:0] cx, cy;
  logic signed [ZW-1:0] z;

  logic [AB-1:0] res_angle;
  logic res_deg;
  logic ov;
  logic [AB-1:0] o_angle;
  logic o_deg;

  logic signed [COORD_BITS-1:0] pin [3];
  assign pin[0] = point.coord_x;
  assign pin[1] = point.coord_y;
  assign pin[2] = point.coord_z;

  assign point.ready       = (state == S_IDLE);
  assign result.valid      = ov;
  assign result.angle      = o_angle;
  assign result.degenerate = o_deg;

  // Operand issue for the shared multiplier.
  logic iss_valid, iss_neg, iss_first, iss_last, iss_shift, iss_dot;
  logic [1:0] iss_idx;
  logic signed [MW-1:0] a_op, b_op;
  logic [1:0] cj, ia, ib, tm, ti, grp;
  logic ct;
  logic signed [MW-1:0] va [3];
  logic signed [MW-1:0] vb [3];

  always_comb begin
    cj = cnt[2:1];
    ct = cnt[0];
    ia = dih_pkg::cross_idx(cj, ct);
    ib = dih_pkg::cross_idx(cj, !ct);
    tm = cnt[1:0];
    grp = cnt[3:2];
    ti = (tm == 2'd3) ? 2'd0 : tm;
    for (int i = 0; i < 3; i++) begin
      va[i] = MW'(v1[i]);
      vb[i] = MW'(v2[i]);
      if (state == S_N2) begin
        va[i] = MW'(v2[i]);
        vb[i] = MW'(v3[i]);
      end else if (state == S_M1) begin
        va[i] = MW'(n1s[i]);
        vb[i] = MW'(vrs[i]);
      end
    end
    iss_valid = 1'b0;
    iss_neg = 1'b0;
    iss_first = 1'b0;
    iss_last = 1'b0;
    iss_shift = 1'b0;
    iss_dot = 1'b0;
    iss_idx = cj;
    a_op = va[ia];
    b_op = vb[ib];
    unique case (state)
      S_N1, S_N2, S_M1: begin
        iss_valid = (cnt < CNTW'(6));
        iss_neg = ct;
        iss_first = !ct;
        iss_last = ct;
      end
      S_DOT: begin
        iss_valid = (cnt < CNTW'(16)) && (tm != 2'd3);
        iss_dot = 1'b1;
        iss_first = (tm == 2'd0);
        iss_last = (tm == 2'd2);
        iss_idx = grp;
        a_op = grp[0] ? MW'(mr[ti]) : MW'(n1s[ti]);
        b_op = grp[1] ? a_op : MW'(n2s[ti]);
      end
      S_XY: begin
        iss_valid = (cnt < CNTW'(4));
        iss_first = !cnt[0];
        iss_shift = !cnt[0];
        iss_last = cnt[0];
        iss_idx = {1'b0, cnt[1]};
        if (cnt[0]) begin
          a_op = MW'({1'b0, dots[{1'b0, cnt[1]}][SW-1:0]});
        end else begin
          a_op = MW'(dots[{1'b0, cnt[1]}] >>> SW);
        end
        b_op = cnt[1] ? MW'({1'b0, ln1}) : MW'({1'b0, lm});
      end
      default: ;
    endcase
  end

  // Accumulator.
  logic signed [AW-1:0] base, term, sum, sum_abs;
  always_comb begin
    base = p_first ? '0 : acc;
    term = p_shift ? (AW'(p) <<< SW) : AW'(p);
    sum = p_neg ? base - term : base + term;
    sum_abs = sum[AW-1] ? -sum : sum;
  end

  // Block scaling: one common truncating shift of three magnitudes.
  logic [AW-1:0] ror, rm_sh [3];
  logic hi16, hi4, hi1, red_done, ror_zero;
  logic signed [NW-1:0] rr [3];
  logic signed [CW-1:0] rc [3];
  logic [AW-1:0] v2mag [3];
  logic signed [AW-1:0] v2ext [3];
  always_comb begin
    ror = rm[0] | rm[1] | rm[2];
    ror_zero = (ror == '0);
    if (phase == PH_CXY) begin
      hi16 = |(ror >> (CB + 15));
      hi4 = |(ror >> (CB + 3));
      hi1 = |(ror >> CB);
    end else begin
      hi16 = |(ror >> (RB + 15));
      hi4 = |(ror >> (RB + 3));
      hi1 = |(ror >> RB);
    end
    red_done = !hi1;
    for (int i = 0; i < 3; i++) begin
      if (hi16) begin
        rm_sh[i] = rm[i] >> 16;
      end else if (hi4) begin
        rm_sh[i] = rm[i] >> 4;
      end else begin
        rm_sh[i] = rm[i] >> 1;
      end
      rr[i] = rs[i] ? NW'(0) - NW'(rm[i][RB-1:0]) : NW'(rm[i][RB-1:0]);
      rc[i] = rs[i] ? CW'(0) - CW'(rm[i][CB-1:0]) : CW'(rm[i][CB-1:0]);
      v2ext[i] = AW'(v2[i]);
      v2mag[i] = v2ext[i][AW-1] ? -v2ext[i] : v2ext[i];
    end
  end

  // Square root step.
  logic [QW:0] sq_try;
  logic sq_ge;
  always_comb begin
    sq_try = sq_r + (QW + 1)'(sq_bit);
    sq_ge = ({1'b0, sq_v} >= sq_try);
  end

  // CORDIC step and output rounding.
  logic [4:0] cs;
  logic signed [XW-1:0] dx, dy, cx0, cy0;
  logic signed [ZW-1:0] at, zq, zq_w;
  always_comb begin
    cs = cnt[4:0];
    dx = cx >>> cs;
    dy = cy >>> cs;
    at = ZW'(dih_pkg::atan_tab(cs));
    cx0 = XW'(rc[0]);
    cy0 = XW'(rc[1]);
    zq = (z + ZHALF) >>> SH;
    zq_w = (zq >= Q360) ? zq - Q360 : zq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_N1;
      cnt <= '0;
      seen <= 2'd0;
      ov <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      if (result.ready && state != S_EMIT) begin
        ov <= 1'b0;
      end
      p_valid <= iss_valid;
      p <= a_op * b_op;
      p_neg <= iss_neg;
      p_first <= iss_first;
      p_last <= iss_last;
      p_shift <= iss_shift;
      p_dot <= iss_dot;
      p_idx <= iss_idx;
      if (p_valid) begin
        acc <= sum;
        if (p_last) begin
          if (p_dot) begin
            dots[p_idx] <= DW'(sum);
          end else begin
            rm[p_idx] <= sum_abs;
            rs[p_idx] <= sum[AW-1];
          end
        end
      end

      unique case (state)
        S_IDLE: begin
          if (point.valid) begin
            if (point.chain_start) begin
              for (int i = 0; i < 3; i++) begin
                hist[0][i] <= pin[i];
                hist[1][i] <= '0;
                hist[2][i] <= '0;
              end
              seen <= 2'd1;
            end else if (seen != 2'd3) begin
              for (int i = 0; i < 3; i++) begin
                hist[seen][i] <= pin[i];
              end
              seen <= seen + 2'd1;
            end else begin
              for (int i = 0; i < 3; i++) begin
                v1[i] <= D'(hist[1][i]) - D'(hist[0][i]);
                v2[i] <= D'(hist[2][i]) - D'(hist[1][i]);
                v3[i] <= D'(pin[i]) - D'(hist[2][i]);
                hist[0][i] <= hist[1][i];
                hist[1][i] <= hist[2][i];
                hist[2][i] <= pin[i];
              end
              cnt <= '0;
              state <= S_N1;
            end
          end
        end
        S_N1, S_N2, S_M1: begin
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(6)) begin
            state <= S_RED;
            if (state == S_N1) begin
              phase <= PH_N1;
            end else if (state == S_N2) begin
              phase <= PH_N2;
            end else begin
              phase <= PH_M1;
            end
          end
        end
        S_RED: begin
          if (!red_done) begin
            for (int i = 0; i < 3; i++) begin
              rm[i] <= rm_sh[i];
            end
          end else if (ror_zero && phase != PH_V2) begin
            res_deg <= 1'b1;
            res_angle <= '0;
            state <= S_EMIT;
          end else begin
            cnt <= '0;
            unique case (phase)
              PH_N1: begin
                n1s <= rr;
                state <= S_N2;
              end
              PH_N2: begin
                n2s <= rr;
                for (int i = 0; i < 3; i++) begin
                  rm[i] <= v2mag[i];
                  rs[i] <= v2[i][D-1];
                end
                phase <= PH_V2;
              end
              PH_V2: begin
                vrs <= rr;
                state <= S_M1;
              end
              PH_M1: begin
                mr <= rr;
                state <= S_DOT;
              end
              default: begin
                if (cx0[XW-1]) begin
                  cx <= -cx0;
                  cy <= -cy0;
                  z <= Z180;
                end else begin
                  cx <= cx0;
                  cy <= cy0;
                  z <= '0;
                end
                state <= S_CORD;
              end
            endcase
          end
        end
        S_DOT: begin
          if (cnt == CNTW'(15)) begin
            sq_v <= QW'(dots[2]);
            sq_r <= '0;
            sq_bit <= QW'(1) << (QW - 2);
            sq_second <= 1'b0;
            cnt <= '0;
            state <= S_SQ;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        S_SQ: begin
          if (cnt == CNTW'(SW)) begin
            cnt <= '0;
            if (!sq_second) begin
              ln1 <= sq_r[SW-1:0];
              sq_v <= QW'(dots[3]);
              sq_r <= '0;
              sq_bit <= QW'(1) << (QW - 2);
              sq_second <= 1'b1;
            end else begin
              lm <= sq_r[SW-1:0];
              rm[2] <= '0;
              rs[2] <= 1'b0;
              state <= S_XY;
            end
          end else begin
            cnt <= cnt + CNTW'(1);
            if (sq_ge) begin
              sq_v <= sq_v - sq_try[QW-1:0];
              sq_r <= (sq_r >> 1) + (QW + 1)'(sq_bit);
            end else begin
              sq_r <= sq_r >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        S_XY: begin
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(4)) begin
            phase <= PH_CXY;
            state <= S_RED;
          end
        end
        S_CORD: begin
          if (cnt == CNTW'(CORDIC_ITERATIONS)) begin
            state <= S_FIN1;
          end else begin
            cnt <= cnt + CNTW'(1);
            if (!cy[XW-1]) begin
              cx <= cx + dy;
              cy <= cy - dx;
              z <= z + at;
            end else begin
              cx <= cx - dy;
              cy <= cy + dx;
              z <= z - at;
            end
          end
        end
        S_FIN1: begin
          if (z[ZW-1]) begin
            z <= z + Z360;
          end else if (z >= Z360) begin
            z <= z - Z360;
          end
          state <= S_FIN2;
        end
        S_FIN2: begin
          res_angle <= zq_w[AB-1:0];
          res_deg <= 1'b0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!ov || result.ready) begin
            ov <= 1'b1;
            o_angle <= res_angle;
            o_deg <= res_deg;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_deg_angle_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.degenerate |-> result.angle == '0)
    else $error("degenerate result with nonzero angle");

  a_seen_after_accept: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.ready |=> seen != 2'd0)
    else $error("point count zero after an accepted point");

  a_product_in_mac: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (state == S_N1 || state == S_N2 || state == S_M1 ||
                 state == S_DOT || state == S_XY))
    else $error("product pending outside a multiply state");

  a_cordic_x_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_CORD |-> !cx[XW-1])
    else $error("CORDIC x went negative");
`endif

endmodule
`default_nettype wire
